FILE: hdl/lstri_pkg.sv
// ----------------------------------------------------------------------------
// lstri_pkg: shared types and constants of the lazy segment tree
// Field widths, controller command codes and the command/status structs
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package lstri_pkg;

    // Fixed widths of the channel fields and the size register.
    localparam int unsigned POS_FW   = 11;
    localparam int unsigned COUNT_FW = 32;

    // Size register value after reset.
    localparam logic [POS_FW-1:0] SIZE_RESET = 11'd1024;

    // Input opcodes.
    localparam logic OP_INC   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Memory read commands.
    localparam logic [1:0] RD_NONE = 2'd0;
    localparam logic [1:0] RD_NODE = 2'd1;
    localparam logic [1:0] RD_KIDS = 2'd2;

    // Memory write commands.
    localparam logic [2:0] WR_NONE  = 3'd0;
    localparam logic [2:0] WR_INC   = 3'd1;
    localparam logic [2:0] WR_KID_A = 3'd2;
    localparam logic [2:0] WR_KID_B = 3'd3;
    localparam logic [2:0] WR_SELF  = 3'd4;
    localparam logic [2:0] WR_CLR   = 3'd5;

    // Walk register commands.
    localparam logic [2:0] STEP_NONE  = 3'd0;
    localparam logic [2:0] STEP_LOAD  = 3'd1;
    localparam logic [2:0] STEP_SPLIT = 3'd2;
    localparam logic [2:0] STEP_LEFT  = 3'd3;
    localparam logic [2:0] STEP_RIGHT = 3'd4;
    localparam logic [2:0] STEP_POP   = 3'd5;

    typedef struct packed {
        logic [1:0] rd;
        logic [2:0] wr;
        logic [2:0] step;
        logic       load_out;
        logic       clr_step;
    } cmd_t;

    typedef struct packed {
        logic is_query_in;
        logic inc_empty_in;
        logic disjoint;
        logic full;
        logic leaf;
        logic pend_zero;
        logic go_left;
        logic stack_empty;
        logic clr_last;
    } status_t;

endpackage

FILE: hdl/lstri_in_if.sv
// ----------------------------------------------------------------------------
// lstri_in_if: request channel
// Carries one increment or query request per beat.
// ----------------------------------------------------------------------------
interface lstri_in_if;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [lstri_pkg::POS_FW-1:0]  range_left;
    logic [lstri_pkg::POS_FW-1:0]  range_right;
    logic [lstri_pkg::POS_FW-1:0]  query_position;

    modport source (output valid, opcode, range_left, range_right, query_position,
                    input ready);
    modport sink (input valid, opcode, range_left, range_right, query_position,
                  output ready);
endinterface

FILE: hdl/lstri_out_if.sv
// ----------------------------------------------------------------------------
// lstri_out_if: result channel
// Carries one query count per beat.
// ----------------------------------------------------------------------------
interface lstri_out_if;
    logic                           valid;
    logic                           ready;
    logic [lstri_pkg::COUNT_FW-1:0] count;

    modport source (output valid, count, input ready);
    modport sink (input valid, count, output ready);
endinterface

FILE: hdl/lstri_dp.sv
// ----------------------------------------------------------------------------
// lstri_dp: segment tree datapath
// Node memory, walk registers, right-child stack, size register and the
// result register. Acts on controller commands; the size register takes cfg writes.
// ----------------------------------------------------------------------------
module lstri_dp #(
    parameter int unsigned MAX_POSITIONS = 1024,
    parameter int unsigned COUNT_WIDTH   = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [lstri_pkg::POS_FW-1:0]    cfg_wr_data,
    input  logic                            opcode,
    input  logic [lstri_pkg::POS_FW-1:0]    range_left,
    input  logic [lstri_pkg::POS_FW-1:0]    range_right,
    input  logic [lstri_pkg::POS_FW-1:0]    query_position,
    input  lstri_pkg::cmd_t                 cmd,
    output lstri_pkg::status_t              status,
    output logic [lstri_pkg::COUNT_FW-1:0]  count
);

    localparam int unsigned FW         = lstri_pkg::POS_FW;
    localparam int unsigned OUT_W      = lstri_pkg::COUNT_FW;
    localparam int unsigned NODE_SLOTS = 4 * MAX_POSITIONS;
    localparam int unsigned NAW        = $clog2(NODE_SLOTS);
    localparam int unsigned POS_W      = $clog2(MAX_POSITIONS + 1);
    localparam int unsigned CMP_W      = ((POS_W > FW) ? POS_W : FW) + 1;
    localparam int unsigned STK_D      = $clog2(MAX_POSITIONS) + 2;
    localparam int unsigned SPW        = $clog2(STK_D + 1);
    localparam int unsigned SIW        = $clog2(STK_D);
    localparam int unsigned CW         = COUNT_WIDTH;

    // Saturating add of two counts.
    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a,
                                              input logic [CW-1:0] b);
        logic [CW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CW] ? {CW{1'b1}} : s[CW-1:0];
    endfunction

    logic [FW-1:0]    size_reg;
    logic [FW-1:0]    ql_reg, qr_reg, qp_reg;
    logic [NAW-1:0]   k_reg;
    logic [POS_W-1:0] lo_reg, hi_reg;
    logic [SPW-1:0]   sp_reg;
    logic [NAW-1:0]   clr_cnt_reg;
    logic [NAW-1:0]   stk_k  [STK_D];
    logic [POS_W-1:0] stk_lo [STK_D];
    logic [POS_W-1:0] stk_hi [STK_D];
    logic [2*CW-1:0]  mem    [NODE_SLOTS];
    logic [2*CW-1:0]  rda_reg, rdb_reg, self_reg;
    logic [OUT_W-1:0] count_reg;

    logic [CMP_W-1:0] size_x, max_x, span_x;
    logic [POS_W-1:0] span, mid, mid_inc;
    logic [CMP_W-1:0] lo_x, hi_x, mid_x, ql_x, qr_x, qp_x;
    logic [NAW-1:0]   kl, kr;
    logic [SIW-1:0]   top_idx, push_idx;
    logic [CW-1:0]    self_pend, self_cnt;
    logic             mem_we;
    logic [NAW-1:0]   mem_wa, rd_addr_a;
    logic [2*CW-1:0]  mem_wd;

    // Size register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= lstri_pkg::SIZE_RESET;
        end
        else if (cfg_wr_en)
        begin
            size_reg <= cfg_wr_data;
        end
    end

    // Root span end, clamped to one and to the tree capacity.
    always_comb
    begin
        size_x = CMP_W'(size_reg);
        max_x  = CMP_W'(MAX_POSITIONS);
        if (size_x == '0)
        begin
            span_x = CMP_W'(1);
        end
        else if (size_x > max_x)
        begin
            span_x = max_x;
        end
        else
        begin
            span_x = size_x;
        end
        span = POS_W'(span_x);
    end

    // Node split point and child indexes.
    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign mid_inc  = mid + POS_W'(1);
    assign kl       = {k_reg[NAW-2:0], 1'b0};
    assign kr       = {k_reg[NAW-2:0], 1'b1};
    assign top_idx  = SIW'(sp_reg - SPW'(1));
    assign push_idx = SIW'(sp_reg);

    // Walk registers and stack pointer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg  <= NAW'(1);
            lo_reg <= POS_W'(1);
            hi_reg <= POS_W'(1);
            sp_reg <= '0;
        end
        else
        begin
            case (cmd.step)
                lstri_pkg::STEP_LOAD:
                begin
                    k_reg  <= NAW'(1);
                    lo_reg <= POS_W'(1);
                    hi_reg <= span;
                    sp_reg <= '0;
                end
                lstri_pkg::STEP_SPLIT:
                begin
                    k_reg  <= kl;
                    hi_reg <= mid;
                    sp_reg <= sp_reg + SPW'(1);
                end
                lstri_pkg::STEP_LEFT:
                begin
                    k_reg  <= kl;
                    hi_reg <= mid;
                end
                lstri_pkg::STEP_RIGHT:
                begin
                    k_reg  <= kr;
                    lo_reg <= mid_inc;
                end
                lstri_pkg::STEP_POP:
                begin
                    k_reg  <= stk_k[top_idx];
                    lo_reg <= stk_lo[top_idx];
                    hi_reg <= stk_hi[top_idx];
                    sp_reg <= sp_reg - SPW'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    // Request fields and the right-child stack.
    always_ff @(posedge clk)
    begin
        if (cmd.step == lstri_pkg::STEP_LOAD)
        begin
            ql_reg <= range_left;
            qr_reg <= range_right;
            qp_reg <= query_position;
        end
        if (cmd.step == lstri_pkg::STEP_SPLIT)
        begin
            stk_k[push_idx]  <= kr;
            stk_lo[push_idx] <= mid_inc;
            stk_hi[push_idx] <= hi_reg;
        end
    end

    // Clearing sweep address.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_cnt_reg <= clr_cnt_reg + NAW'(1);
        end
    end

    // Write port selection.
    assign self_pend = self_reg[2*CW-1:CW];
    assign self_cnt  = self_reg[CW-1:0];

    always_comb
    begin
        mem_we = 1'b1;
        mem_wa = k_reg;
        mem_wd = '0;
        case (cmd.wr)
            lstri_pkg::WR_INC:
            begin
                mem_wd = {sat_add(rda_reg[2*CW-1:CW], CW'(1)),
                          sat_add(rda_reg[CW-1:0], CW'(1))};
            end
            lstri_pkg::WR_KID_A:
            begin
                mem_wa = kl;
                mem_wd = {sat_add(rda_reg[2*CW-1:CW], self_pend),
                          sat_add(rda_reg[CW-1:0], self_pend)};
            end
            lstri_pkg::WR_KID_B:
            begin
                mem_wa = kr;
                mem_wd = {sat_add(rdb_reg[2*CW-1:CW], self_pend),
                          sat_add(rdb_reg[CW-1:0], self_pend)};
            end
            lstri_pkg::WR_SELF:
            begin
                mem_wd = {{CW{1'b0}}, self_cnt};
            end
            lstri_pkg::WR_CLR:
            begin
                mem_wa = clr_cnt_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign rd_addr_a = (cmd.rd == lstri_pkg::RD_KIDS) ? kl : k_reg;

    // Node memory: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (cmd.rd != lstri_pkg::RD_NONE)
        begin
            rda_reg <= mem[rd_addr_a];
            rdb_reg <= mem[kr];
        end
        if (cmd.rd == lstri_pkg::RD_KIDS)
        begin
            self_reg <= rda_reg;
        end
        if (cmd.load_out)
        begin
            count_reg <= OUT_W'(rda_reg[CW-1:0]);
        end
    end

    assign count = count_reg;

    // Status toward the controller.
    assign lo_x  = CMP_W'(lo_reg);
    assign hi_x  = CMP_W'(hi_reg);
    assign mid_x = CMP_W'(mid);
    assign ql_x  = CMP_W'(ql_reg);
    assign qr_x  = CMP_W'(qr_reg);
    assign qp_x  = CMP_W'(qp_reg);

    always_comb
    begin
        status.is_query_in  = (opcode == lstri_pkg::OP_QUERY);
        status.inc_empty_in = (range_left > range_right);
        status.disjoint     = (lo_x > qr_x) || (hi_x < ql_x);
        status.full         = (ql_x <= lo_x) && (hi_x <= qr_x);
        status.leaf         = (lo_reg == hi_reg);
        status.pend_zero    = (rda_reg[2*CW-1:CW] == '0);
        status.go_left      = (qp_x <= mid_x);
        status.stack_empty  = (sp_reg == '0);
        status.clr_last     = (clr_cnt_reg == NAW'(NODE_SLOTS - 1));
    end

`ifndef NO_ASSERTIONS
    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SPW'(STK_D))
        else $error("right-child stack overflow");
    a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
        lo_reg <= hi_reg)
        else $error("node span has lo above hi");
    a_rd_wr_apart: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rd != lstri_pkg::RD_NONE) |-> (cmd.wr == lstri_pkg::WR_NONE))
        else $error("memory read and write in the same cycle");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step == lstri_pkg::STEP_POP) |-> (sp_reg != '0))
        else $error("pop from empty stack");
`endif

endmodule

FILE: hdl/lstri_ctrl.sv
// ----------------------------------------------------------------------------
// lstri_ctrl: segment tree controller
// State machine that sequences the clearing sweep, range increments and
// point queries, and owns both channel handshakes.
// ----------------------------------------------------------------------------
module lstri_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  lstri_pkg::status_t  status,
    output lstri_pkg::cmd_t     cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_VISIT  = 3'd2;
    localparam logic [2:0] S_EVAL   = 3'd3;
    localparam logic [2:0] S_PUSH_A = 3'd4;
    localparam logic [2:0] S_PUSH_B = 3'd5;
    localparam logic [2:0] S_PUSH_S = 3'd6;
    localparam logic [2:0] S_QLEAF  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       mode_q_reg, mode_q_next;
    logic       out_valid_reg, out_valid_next;
    logic [2:0] descend;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            mode_q_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_q_reg    <= mode_q_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Query steps toward its position; an increment splits and stacks the right child.
    always_comb
    begin
        if (mode_q_reg)
        begin
            descend = status.go_left ? lstri_pkg::STEP_LEFT : lstri_pkg::STEP_RIGHT;
        end
        else
        begin
            descend = lstri_pkg::STEP_SPLIT;
        end
    end

    // Next state and command decode.
    always_comb
    begin
        state_next   = state_reg;
        mode_q_next  = mode_q_reg;
        in_ready     = 1'b0;
        cmd.rd       = lstri_pkg::RD_NONE;
        cmd.wr       = lstri_pkg::WR_NONE;
        cmd.step     = lstri_pkg::STEP_NONE;
        cmd.load_out = 1'b0;
        cmd.clr_step = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.wr       = lstri_pkg::WR_CLR;
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.step    = lstri_pkg::STEP_LOAD;
                    mode_q_next = status.is_query_in;
                    if (status.is_query_in || !status.inc_empty_in)
                    begin
                        state_next = S_VISIT;
                    end
                end
            end
            S_VISIT:
            begin
                if (mode_q_reg)
                begin
                    cmd.rd     = lstri_pkg::RD_NODE;
                    state_next = status.leaf ? S_QLEAF : S_EVAL;
                end
                else if (status.disjoint)
                begin
                    if (status.stack_empty)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.step = lstri_pkg::STEP_POP;
                    end
                end
                else
                begin
                    cmd.rd     = lstri_pkg::RD_NODE;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (!mode_q_reg && status.full)
                begin
                    cmd.wr = lstri_pkg::WR_INC;
                    if (status.stack_empty)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.step   = lstri_pkg::STEP_POP;
                        state_next = S_VISIT;
                    end
                end
                else if (status.pend_zero)
                begin
                    cmd.step   = descend;
                    state_next = S_VISIT;
                end
                else
                begin
                    cmd.rd     = lstri_pkg::RD_KIDS;
                    state_next = S_PUSH_A;
                end
            end
            S_PUSH_A:
            begin
                cmd.wr     = lstri_pkg::WR_KID_A;
                state_next = S_PUSH_B;
            end
            S_PUSH_B:
            begin
                cmd.wr     = lstri_pkg::WR_KID_B;
                state_next = S_PUSH_S;
            end
            S_PUSH_S:
            begin
                cmd.wr     = lstri_pkg::WR_SELF;
                cmd.step   = descend;
                state_next = S_VISIT;
            end
            S_QLEAF:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result beat valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: hdl/lazy_segment_tree_range_inc_core.sv
// ----------------------------------------------------------------------------
// lazy_segment_tree_range_inc_core: lazy segment tree, range +1, point query
// Positions 1..size_in_use; increments and pending values saturate.
// ----------------------------------------------------------------------------
//
//   channel   direction  beat contents
//   in_ch     in         opcode, range_left, range_right, query_position
//   out_ch    out        count (one beat per query)
//   cfg       in         size_in_use write (cfg_wr_en, cfg_wr_data)
//
// After reset a clearing sweep writes all 4*MAX_POSITIONS node entries, one a
// cycle, and no request is taken until it ends.
// An increment skips disjoint nodes, adds one to covered nodes and splits the
// rest; a pending value is pushed down to both children and the node written
// back in turn through the single write port. A query descends one tree level
// at a time, with the same push-down, and loads the count at the leaf.
// A request is taken only when the previous one is done; a held result does
// not stall intake until the next query reaches its leaf.
module lazy_segment_tree_range_inc_core #(
    parameter int unsigned MAX_POSITIONS = 1024,
    parameter int unsigned COUNT_WIDTH   = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [lstri_pkg::POS_FW-1:0]  cfg_wr_data,
    lstri_in_if.sink                      in_ch,
    lstri_out_if.source                   out_ch
);

    lstri_pkg::cmd_t    cmd;
    lstri_pkg::status_t status;

    // Sequencing.
    lstri_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Node storage and walk.
    lstri_dp #(
        .MAX_POSITIONS (MAX_POSITIONS),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .opcode         (in_ch.opcode),
        .range_left     (in_ch.range_left),
        .range_right    (in_ch.range_right),
        .query_position (in_ch.query_position),
        .cmd            (cmd),
        .status         (status),
        .count          (out_ch.count)
    );

endmodule
